// File: design/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: field widths, byte classes,
// result status codes and the code point limit. No dependencies.
package u8sd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CpW    = 21;
	localparam int unsigned StatW  = 2;
	localparam int unsigned LenW   = 3;
	localparam int unsigned TrailW = 2;

	typedef logic [ByteW-1:0]  byte_t;
	typedef logic [CpW-1:0]    cp_t;
	typedef logic [StatW-1:0]  stat_t;
	typedef logic [LenW-1:0]   len_t;
	typedef logic [TrailW-1:0] trail_t;

	// Result status codes.
	localparam stat_t ST_OK          = 2'd0;
	localparam stat_t ST_NOT_UTF8    = 2'd1;
	localparam stat_t ST_ABOVE_LIMIT = 2'd2;

	// Byte class boundaries and payload masks.
	localparam byte_t ASCII_MAX  = 8'h7F;
	localparam byte_t LEAD2_MIN  = 8'hC0;
	localparam byte_t LEAD3_MIN  = 8'hE0;
	localparam byte_t LEAD4_MIN  = 8'hF0;
	localparam byte_t TRAIL_TAG  = 8'h80;
	localparam byte_t TAG_MASK   = 8'hC0;
	localparam byte_t TRAIL_MASK = 8'h3F;
	localparam byte_t LEAD2_MASK = 8'h1F;
	localparam byte_t LEAD3_MASK = 8'h0F;
	localparam byte_t LEAD4_MASK = 8'h07;

	localparam cp_t CP_LIMIT = 21'h10FFFF;

	// Sequence lengths.
	localparam len_t LEN_NONE = 3'd0;
	localparam len_t LEN_1    = 3'd1;
	localparam len_t LEN_2    = 3'd2;
	localparam len_t LEN_3    = 3'd3;
	localparam len_t LEN_4    = 3'd4;

endpackage

// File: design/u8sd_byte_if.sv
// Byte channel into the UTF-8 stream decoder: valid, ready and one raw byte.
// Depends on u8sd_pkg.
interface u8sd_byte_if;
	import u8sd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// File: design/u8sd_char_if.sv
// Character channel out of the UTF-8 stream decoder: valid, ready, code point,
// status and sequence length. Depends on u8sd_pkg.
interface u8sd_char_if;
	import u8sd_pkg::*;

	logic  valid;
	logic  ready;
	cp_t   code_point;
	stat_t status;
	len_t  seq_len;

	modport source (output valid, output code_point, output status, output seq_len,
		input ready);
	modport sink   (input valid, input code_point, input status, input seq_len,
		output ready);
endinterface

// File: design/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder top level: byte register, decode step and result register.
// Depends on u8sd_pkg, u8sd_byte_if and u8sd_char_if.
//
//   channel    | direction | beat carries
//   -----------+-----------+-------------------------------------
//   in_byte    | sink      | data_byte (8 bits)
//   out_char   | source    | code_point (21), status (2), seq_len (3)
//
// One byte enters per cycle while in_byte.ready is high. An accepted byte is
// loaded into the byte register and any result into the result register.
// The rate is set by the single decode step between the two registers.
// Reset (arst_n low) empties both registers and returns the decoder to idle.
// A stall on out_char holds the result; the byte register still fills, and
// in_byte.ready falls only when both registers are occupied and the result
// is not being taken.
module utf8_stream_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	u8sd_byte_if.sink           in_byte,
	u8sd_char_if.source         out_char
);
	import u8sd_pkg::*;

	// Byte register stage.
	logic   valid_s1;
	byte_t  byte_s1;

	// Decoder state: value gathered so far, trail bytes still due and the
	// length of the open sequence.
	cp_t    part_q;
	trail_t trails_q;
	len_t   len_q;

	// Result register.
	logic   res_valid_q;
	cp_t    res_cp_q;
	stat_t  res_stat_q;
	len_t   res_len_q;

	// Decode step outputs.
	logic   emit;
	cp_t    emit_cp;
	stat_t  emit_stat;
	len_t   emit_len;
	cp_t    part_d;
	trail_t trails_d;
	len_t   len_d;
	cp_t    shifted;

	logic   res_free;
	logic   advance;

	// The result register can take a new value when it is empty or its
	// current beat is being taken this cycle. The byte register moves on
	// under the same condition, so the decoder state only changes when the
	// byte it has decoded can leave.
	assign res_free = !res_valid_q || out_char.ready;
	assign advance  = valid_s1 && res_free;
	assign in_byte.ready = !valid_s1 || res_free;

	// A trail byte adds six bits below the gathered value; the top bits fall
	// away at the width of a code point.
	assign shifted = {part_q[CpW-7:0], byte_s1[5:0]};

	always_comb begin
		emit      = 1'b0;
		emit_cp   = '0;
		emit_stat = ST_OK;
		emit_len  = LEN_NONE;
		part_d    = part_q;
		trails_d  = trails_q;
		len_d     = len_q;
		if (trails_q == '0) begin
			if (byte_s1 <= ASCII_MAX) begin
				emit     = 1'b1;
				emit_cp  = CpW'(byte_s1);
				emit_len = LEN_1;
			end else if (byte_s1 < LEAD2_MIN) begin
				// A trail byte with no open sequence is dropped.
				emit      = 1'b1;
				emit_stat = ST_NOT_UTF8;
				part_d    = '0;
				len_d     = LEN_NONE;
			end else if (byte_s1 < LEAD3_MIN) begin
				part_d   = CpW'(byte_s1 & LEAD2_MASK);
				trails_d = 2'd1;
				len_d    = LEN_2;
			end else if (byte_s1 < LEAD4_MIN) begin
				part_d   = CpW'(byte_s1 & LEAD3_MASK);
				trails_d = 2'd2;
				len_d    = LEN_3;
			end else begin
				// Leads from 0xF8 up are taken as four-byte leads as well.
				part_d   = CpW'(byte_s1 & LEAD4_MASK);
				trails_d = 2'd3;
				len_d    = LEN_4;
			end
		end else if ((byte_s1 & TAG_MASK) != TRAIL_TAG) begin
			// A broken sequence: the offending byte is dropped, not re-read
			// as a lead, and the decoder goes back to idle.
			emit      = 1'b1;
			emit_stat = ST_NOT_UTF8;
			part_d    = '0;
			trails_d  = '0;
			len_d     = LEN_NONE;
		end else if (trails_q != 2'd1) begin
			part_d   = shifted;
			trails_d = trails_q - 2'd1;
		end else begin
			// Last trail byte: the sequence is complete.
			emit     = 1'b1;
			part_d   = '0;
			trails_d = '0;
			len_d    = LEN_NONE;
			if (shifted > CP_LIMIT) begin
				emit_stat = ST_ABOVE_LIMIT;
			end else begin
				emit_cp  = shifted;
				emit_len = len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			part_q      <= '0;
			trails_q    <= '0;
			len_q       <= LEN_NONE;
			res_valid_q <= 1'b0;
		end else begin
			if (in_byte.ready) begin
				valid_s1 <= in_byte.valid;
			end
			if (advance) begin
				part_q   <= part_d;
				trails_q <= trails_d;
				len_q    <= len_d;
			end
			if (res_free) begin
				res_valid_q <= advance && emit;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_byte.ready && in_byte.valid) begin
			byte_s1 <= in_byte.data_byte;
		end
		if (advance && emit) begin
			res_cp_q   <= emit_cp;
			res_stat_q <= emit_stat;
			res_len_q  <= emit_len;
		end
	end

	assign out_char.valid      = res_valid_q;
	assign out_char.code_point = res_cp_q;
	assign out_char.status     = res_stat_q;
	assign out_char.seq_len    = res_len_q;

`ifndef ASSERT_OFF
	// An error result never carries a code point or a length.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stat_q != ST_OK) |-> (res_cp_q == '0 && res_len_q == LEN_NONE))
		else $error("error result with non-zero code point or length");

	// While a sequence is open its length is above one and above the trail bytes due.
	a_open_len: assert property (@(posedge clk) disable iff (!arst_n)
		(trails_q != '0) |-> (len_q > LEN_1 && {1'b0, trails_q} < len_q))
		else $error("open sequence length disagrees with trail count");

	// A good result never lies above the code point limit.
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stat_q == ST_OK) |->
		(res_cp_q <= CP_LIMIT && res_len_q != LEN_NONE))
		else $error("good result above limit or without length");

	// With no result waiting, the byte side is never held off.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> in_byte.ready)
		else $error("input stalled with empty result register");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for utf8_stream_decoder_unit: random and directed byte streams
// against a cycle-free decoder kept in a scoreboard class.
// Depends on u8sd_pkg, u8sd_byte_if, u8sd_char_if and the decoder top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u8sd_pkg::*;

	// Generous bound: about 425 bytes, each with a random gap and a random
	// character stall, plus the drain pauses.
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BYTES = 400;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct packed {
		cp_t   code_point;
		stat_t status;
		len_t  seq_len;
	} char_beat_t;

	// Tracks the decoder state and keeps the characters still owed by the block,
	// oldest first.
	class char_scoreboard;
		cp_t        partial;
		trail_t     trails_left;
		len_t       open_len;
		char_beat_t chars_due[$];
		int unsigned mismatches;

		function new();
			go_idle();
			mismatches = 0;
		endfunction

		function void go_idle();
			partial     = '0;
			trails_left = '0;
			open_len    = LEN_NONE;
		endfunction

		function void owe_char(cp_t cp, stat_t st, len_t len);
			char_beat_t beat;
			beat.code_point = cp;
			beat.status     = st;
			beat.seq_len    = len;
			chars_due.push_back(beat);
		endfunction

		function int unsigned pending();
			return chars_due.size();
		endfunction

		// Advances the decoder by one accepted byte and notes the character it
		// completes or breaks, if any.
		function void byte_accepted(byte_t b);
			if (trails_left == 0) begin
				if (b <= ASCII_MAX) begin
					owe_char(cp_t'(b), ST_OK, LEN_1);
				end else if (b < LEAD2_MIN) begin
					// A trail byte with no sequence open.
					go_idle();
					owe_char('0, ST_NOT_UTF8, LEN_NONE);
				end else if (b < LEAD3_MIN) begin
					partial     = cp_t'(b & LEAD2_MASK);
					trails_left = 2'd1;
					open_len    = LEN_2;
				end else if (b < LEAD4_MIN) begin
					partial     = cp_t'(b & LEAD3_MASK);
					trails_left = 2'd2;
					open_len    = LEN_3;
				end else begin
					partial     = cp_t'(b & LEAD4_MASK);
					trails_left = 2'd3;
					open_len    = LEN_4;
				end
			end else if ((b & TAG_MASK) != TRAIL_TAG) begin
				// The offending byte is swallowed, not taken as a new lead.
				go_idle();
				owe_char('0, ST_NOT_UTF8, LEN_NONE);
			end else begin
				partial     = (partial << 6) | cp_t'(b & TRAIL_MASK);
				trails_left = trails_left - 2'd1;
				if (trails_left == 0) begin
					if (partial > CP_LIMIT)
						owe_char('0, ST_ABOVE_LIMIT, LEN_NONE);
					else
						owe_char(partial, ST_OK, open_len);
					go_idle();
				end
			end
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_char(char_beat_t got);
			char_beat_t want;
			if (chars_due.size() == 0) begin
				report($sformatf("character beat cp=%0h st=%0d len=%0d with none owed",
					got.code_point, got.status, got.seq_len));
			end else begin
				want = chars_due.pop_front();
				if (got.code_point !== want.code_point)
					report($sformatf("code_point %0h, expected %0h",
						got.code_point, want.code_point));
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.seq_len !== want.seq_len)
					report($sformatf("seq_len %0d, expected %0d", got.seq_len, want.seq_len));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	bit tx_calm;
	bit rx_calm;

	char_scoreboard sb = new();

	u8sd_byte_if in_byte();
	u8sd_char_if out_char();

	utf8_stream_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.out_char (out_char)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost character ends the run here.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one byte after a random gap and returns at the edge that takes it.
	// Handshake signals are looked at on the falling edge, where nothing moves,
	// and valid is only lowered when a gap actually follows, so it never sees
	// two assignments at the same edge. Now and then the sender switches into
	// a calm stretch with no gaps at all.
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_byte.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_byte.valid     <= 1'b1;
		in_byte.data_byte <= b;
		do @(negedge clk); while (in_byte.ready !== 1'b1);
		sb.byte_accepted(b);
		@(posedge clk);
	endtask

	// Holds the byte channel quiet until every owed character has come out.
	task automatic drain_pause();
		in_byte.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic byte_t random_trail();
		return TRAIL_TAG | (byte_t'($urandom) & TRAIL_MASK);
	endfunction

	function automatic byte_t random_non_trail();
		byte_t b;
		do b = byte_t'($urandom); while ((b & TAG_MASK) == TRAIL_TAG);
		return b;
	endfunction

	function automatic byte_t random_lead(input int unsigned len);
		case (len)
			2:       return byte_t'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1));
			3:       return byte_t'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
			default: return byte_t'($urandom_range(LEAD4_MIN, 8'hFF));
		endcase
	endfunction

	// Mostly well-formed characters with random payload, the rest stray trail
	// bytes, sequences cut short by a foreign byte, and raw noise.
	task automatic send_random_group(output int unsigned count);
		int unsigned kind;
		int unsigned len;
		int unsigned trails;
		kind  = $urandom_range(0, 15);
		count = 0;
		if (kind <= 4) begin
			send_byte(byte_t'($urandom_range(0, ASCII_MAX)));
			count = 1;
		end else if (kind <= 11) begin
			len = (kind <= 6) ? 2 : (kind <= 8) ? 3 : 4;
			// Half the 4-byte leads stay in the legal range so that most of
			// them can come out below the limit.
			if (len == 4 && $urandom_range(0, 1) == 0)
				send_byte(byte_t'($urandom_range(LEAD4_MIN, LEAD4_MIN + 4)));
			else
				send_byte(random_lead(len));
			repeat (len - 1) send_byte(random_trail());
			count = len;
		end else if (kind == 12) begin
			send_byte(random_trail());
			count = 1;
		end else if (kind <= 14) begin
			len    = $urandom_range(2, 4);
			trails = $urandom_range(0, len - 2);
			send_byte(random_lead(len));
			repeat (trails) send_byte(random_trail());
			send_byte(random_non_trail());
			count = trails + 2;
		end else begin
			send_byte(byte_t'($urandom));
			count = 1;
		end
	endtask

	// Character sink: draws a stall per beat, with calm stretches of none, and
	// checks each beat on the falling edge before the edge that takes it.
	initial begin
		char_beat_t got;
		rx_calm = 1'b0;
		out_char.ready <= 1'b0;
		@(posedge clk);
		forever begin
			int unsigned stall;
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				out_char.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_char.ready <= 1'b1;
			do @(negedge clk); while (out_char.valid !== 1'b1);
			got.code_point = out_char.code_point;
			got.status     = out_char.status;
			got.seq_len    = out_char.seq_len;
			sb.check_char(got);
			@(posedge clk);
		end
	end

	// Byte source and run control.
	initial begin
		byte_t directed[$];
		int unsigned sent;
		int unsigned n;
		arst_n            <= 1'b0;
		in_byte.valid     <= 1'b0;
		in_byte.data_byte <= '0;
		tx_calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: both ends of the ASCII range, an overlong two-byte
		// form, the largest two-byte value, a surrogate, the last legal code
		// point, a lead from the F8..FF range that decodes past the limit, a
		// stray trail byte, a three-byte sequence broken by ASCII, and a
		// four-byte lead followed straight away by another lead byte.
		directed = '{8'h00, 8'h7F,
			8'hC0, 8'h80,
			8'hDF, 8'hBF,
			8'hED, 8'hA0, 8'h80,
			8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hFF, 8'hBF, 8'hBF, 8'hBF,
			8'h80,
			8'hE2, 8'h82, 8'h41,
			8'hF0, 8'hFF};
		foreach (directed[i])
			send_byte(directed[i]);

		// Let the block empty completely once before the random part.
		drain_pause();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			send_random_group(n);
			sent += n;
			if ($urandom_range(0, 99) == 0)
				drain_pause();
		end
		in_byte.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		// A few more edges so that a surplus beat would still be caught.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// File: filelist.f
design/u8sd_pkg.sv
design/u8sd_byte_if.sv
design/u8sd_char_if.sv
design/utf8_stream_decoder_unit.sv
tb/sv/tb.sv
